### hdl/tsg_pkg.sv
// Shared types and codes of the triangle span generator.
package tsg_pkg;

	localparam int VERT_W  = 16;
	localparam int COLOR_W = 32;
	localparam int EDGE_W  = 32;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SEL_LONG,
		SEL_UPPER,
		SEL_LOWER
	} sel_t;

endpackage

### hdl/triangle_span_generator.sv
// Triangle span generator: vertex sort, serial slope division and span scan.
//
// A load item (command 0) computes the three inverse slopes one after another
// through a single restoring divider that retires one quotient bit per cycle
// (STEP_FRAC_BITS+17 bits), with an operand state before and a result state
// after each; no new item is taken until all three are done. A step item
// (command 1) yields its span in the output register on the next cycle; steps
// follow one per cycle while the consumer takes spans and no load is running.
// Steps with no triangle armed are taken and yield nothing.
module triangle_span_generator #(
	parameter int COORD_FRAC_BITS = 4,
	parameter int STEP_FRAC_BITS  = 16,
	parameter int PIXEL_BITS      = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         command,
	input  logic signed [15:0]           vert0_x,
	input  logic signed [15:0]           vert0_y,
	input  logic signed [15:0]           vert1_x,
	input  logic signed [15:0]           vert1_y,
	input  logic signed [15:0]           vert2_x,
	input  logic signed [15:0]           vert2_y,
	input  logic [31:0]                  fill_color,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [PIXEL_BITS-1:0] span_row,
	output logic signed [PIXEL_BITS-1:0] span_x_first,
	output logic signed [PIXEL_BITS-1:0] span_x_final,
	output logic                         span_empty,
	output logic [31:0]                  span_color,
	output logic                         last_span
);
	import tsg_pkg::*;

	localparam int QW = STEP_FRAC_BITS + 17;
	localparam int CW = $clog2(QW + 1);
	localparam int P  = PIXEL_BITS;
	localparam logic signed [33:0] HALF_Y = (34'sd1 <<< COORD_FRAC_BITS) >>> 1;
	localparam logic signed [33:0] HALF_S = (34'sd1 <<< STEP_FRAC_BITS) >>> 1;
	localparam logic signed [33:0] PMAX   = (34'sd1 <<< (P - 1)) - 34'sd1;
	localparam logic signed [33:0] PMIN   = -(34'sd1 <<< (P - 1));

	function automatic logic signed [P-1:0] sat_pix(input logic signed [33:0] v);
		if (v > PMAX) return PMAX[P-1:0];
		if (v < PMIN) return PMIN[P-1:0];
		return v[P-1:0];
	endfunction

	function automatic logic [EDGE_W-1:0] to_edge(input logic signed [VERT_W-1:0] c);
		logic signed [47:0] w;
		w = 48'(c) <<< (STEP_FRAC_BITS - COORD_FRAC_BITS);
		return w[EDGE_W-1:0];
	endfunction

	state_t state_q, state_d;
	sel_t   sel_q;

	logic signed [VERT_W-1:0] tx_q, ty_q, mx_q, my_q, bx_q, by_q;
	logic                     active_q, region_q, mol_q;
	logic signed [P-1:0]      row_q, end_row_q, bot_row_q;
	logic [EDGE_W-1:0]        left_x_q, right_x_q, left_step_q, right_step_q;
	logic [EDGE_W-1:0]        lower_step_q, long_step_q;
	logic [COLOR_W-1:0]       color_q;

	logic [QW-1:0]    num_q;
	logic [17:0]      rem_q;
	logic [16:0]      den_q;
	logic             neg_q, zero_q;
	logic [CW-1:0]    cnt_q;

	logic out_valid_q;
	logic accept, div_start, div_step, div_done;

	// vertex sort
	logic signed [VERT_W-1:0] sx_t, sy_t, sx_m, sy_m, sx_b, sy_b;
	logic                     s_mol;

	always_comb begin
		if (vert0_y >= vert1_y) begin
			if (vert1_y >= vert2_y) begin
				{sx_t, sy_t, sx_m, sy_m, sx_b, sy_b} =
					{vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y};
				s_mol = 1'b1;
			end else if (vert0_y >= vert2_y) begin
				{sx_t, sy_t, sx_m, sy_m, sx_b, sy_b} =
					{vert0_x, vert0_y, vert2_x, vert2_y, vert1_x, vert1_y};
				s_mol = 1'b0;
			end else begin
				{sx_t, sy_t, sx_m, sy_m, sx_b, sy_b} =
					{vert2_x, vert2_y, vert0_x, vert0_y, vert1_x, vert1_y};
				s_mol = 1'b1;
			end
		end else begin
			if (vert0_y >= vert2_y) begin
				{sx_t, sy_t, sx_m, sy_m, sx_b, sy_b} =
					{vert1_x, vert1_y, vert0_x, vert0_y, vert2_x, vert2_y};
				s_mol = 1'b0;
			end else if (vert1_y >= vert2_y) begin
				{sx_t, sy_t, sx_m, sy_m, sx_b, sy_b} =
					{vert1_x, vert1_y, vert2_x, vert2_y, vert0_x, vert0_y};
				s_mol = 1'b1;
			end else begin
				{sx_t, sy_t, sx_m, sy_m, sx_b, sy_b} =
					{vert2_x, vert2_y, vert1_x, vert1_y, vert0_x, vert0_y};
				s_mol = 1'b0;
			end
		end
	end

	logic signed [P-1:0] r_t, r_m, r_b;
	assign r_t = sat_pix((34'(sy_t) + HALF_Y) >>> COORD_FRAC_BITS);
	assign r_m = sat_pix((34'(sy_m) + HALF_Y) >>> COORD_FRAC_BITS);
	assign r_b = sat_pix((34'(sy_b) + HALF_Y) >>> COORD_FRAC_BITS);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && command == CMD_LOAD) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_RUN;
			ST_RUN:  if (cnt_q == CW'(QW - 1)) state_d = ST_DONE;
			ST_DONE: state_d = (sel_q == SEL_LOWER) ? ST_IDLE : ST_LOAD;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		div_step  = 1'b0;
		div_done  = 1'b0;
		case (state_q)
			ST_IDLE: in_ready  = !out_valid_q || out_ready;
			ST_LOAD: div_start = 1'b1;
			ST_RUN:  div_step  = 1'b1;
			ST_DONE: div_done  = 1'b1;
			default: in_ready  = 1'b0;
		endcase
	end

	assign accept = in_valid && in_ready;

	// divider operands
	logic signed [VERT_W-1:0] hx, hy, lx, ly;
	logic signed [16:0]       dx, dy;
	logic [16:0]              adx, ady;

	always_comb begin
		case (sel_q)
			SEL_LONG:  {hx, hy, lx, ly} = {tx_q, ty_q, bx_q, by_q};
			SEL_UPPER: {hx, hy, lx, ly} = {tx_q, ty_q, mx_q, my_q};
			SEL_LOWER: {hx, hy, lx, ly} = {mx_q, my_q, bx_q, by_q};
			default:   {hx, hy, lx, ly} = {tx_q, ty_q, bx_q, by_q};
		endcase
		dx  = 17'(lx) - 17'(hx);
		dy  = 17'(ly) - 17'(hy);
		adx = dx[16] ? 17'(-dx) : 17'(dx);
		ady = dy[16] ? 17'(-dy) : 17'(dy);
	end

	logic [17:0] rem_sh;
	logic        q_bit;
	assign rem_sh = {rem_q[16:0], num_q[QW-1]};
	assign q_bit  = rem_sh >= 18'(den_q);

	logic [63:0]       q_ext;
	logic [EDGE_W-1:0] q_res;
	always_comb begin
		q_ext = 64'(num_q);
		if (zero_q) q_res = '0;
		else if (neg_q) q_res = (q_ext > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q_ext);
		else q_res = (q_ext > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_ext[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= SEL_LONG;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept && command == CMD_LOAD) sel_q <= SEL_LONG;
			else if (div_done) begin
				case (sel_q)
					SEL_LONG:  sel_q <= SEL_UPPER;
					SEL_UPPER: sel_q <= SEL_LOWER;
					default:   sel_q <= SEL_LONG;
				endcase
			end
			if (div_start) cnt_q <= '0;
			else if (div_step) cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			num_q  <= QW'(adx) << STEP_FRAC_BITS;
			rem_q  <= '0;
			den_q  <= ady;
			neg_q  <= dx[16] ^ dy[16];
			zero_q <= (dy == 17'sd0);
		end else if (div_step) begin
			rem_q <= q_bit ? (rem_sh - 18'(den_q)) : rem_sh;
			num_q <= {num_q[QW-2:0], q_bit};
		end
		if (div_done && sel_q == SEL_LONG) long_step_q <= q_res;
		if (div_done && sel_q == SEL_LOWER) lower_step_q <= q_res;
	end

	// span path
	logic signed [33:0]  xf, xl;
	logic                at_end;
	assign xf     = (34'($signed(left_x_q)) + HALF_S) >>> STEP_FRAC_BITS;
	assign xl     = (34'($signed(right_x_q)) + HALF_S) >>> STEP_FRAC_BITS;
	assign at_end = row_q <= end_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			region_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && command == CMD_STEP && active_q) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (accept && command == CMD_LOAD) begin
				active_q <= 1'b1;
				region_q <= 1'b0;
			end else if (accept && active_q && at_end) begin
				if (region_q) active_q <= 1'b0;
				else region_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && command == CMD_LOAD) begin
			{tx_q, ty_q, mx_q, my_q, bx_q, by_q} <= {sx_t, sy_t, sx_m, sy_m, sx_b, sy_b};
			mol_q     <= s_mol;
			row_q     <= r_t;
			end_row_q <= r_m;
			bot_row_q <= r_b;
			left_x_q  <= to_edge(sx_t);
			right_x_q <= to_edge(sx_t);
			color_q   <= fill_color;
		end else if (accept && active_q) begin
			span_row     <= row_q;
			span_x_first <= sat_pix(xf);
			span_x_final <= sat_pix(xl);
			span_empty   <= xf > xl;
			span_color   <= color_q;
			last_span    <= region_q && at_end;
			if (at_end && !region_q) begin
				end_row_q <= bot_row_q;
				if (mol_q) begin
					left_x_q     <= to_edge(mx_q);
					right_x_q    <= right_x_q - right_step_q;
					left_step_q  <= lower_step_q;
					right_step_q <= long_step_q;
				end else begin
					left_x_q     <= left_x_q - left_step_q;
					right_x_q    <= to_edge(mx_q);
					left_step_q  <= long_step_q;
					right_step_q <= lower_step_q;
				end
			end else begin
				left_x_q  <= left_x_q - left_step_q;
				right_x_q <= right_x_q - right_step_q;
				if (!at_end) row_q <= row_q - P'(1);
			end
		end else if (div_done && sel_q == SEL_UPPER) begin
			left_step_q  <= mol_q ? q_res : long_step_q;
			right_step_q <= mol_q ? long_step_q : q_res;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/tsg_checker.sv
// Port-level checks of the triangle span generator, bound to the top level.
module tsg_checker #(
	parameter int PIXEL_BITS = 12
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         command,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [PIXEL_BITS-1:0] span_row,
	input logic signed [PIXEL_BITS-1:0] span_x_first,
	input logic signed [PIXEL_BITS-1:0] span_x_final,
	input logic                         span_empty
);
	import tsg_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("span dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(span_row) && $stable(span_x_first))
		else $error("span changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (span_empty ? span_x_first >= span_x_final
			: span_x_first <= span_x_final))
		else $error("empty flag disagrees with span ends");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_LOAD && (!out_valid || out_ready)
		|=> !out_valid)
		else $error("load produced a span");

endmodule

bind triangle_span_generator tsg_checker #(.PIXEL_BITS(PIXEL_BITS)) u_tsg_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.command(command), .out_valid(out_valid), .out_ready(out_ready),
	.span_row(span_row), .span_x_first(span_x_first), .span_x_final(span_x_final),
	.span_empty(span_empty)
);
